### sv/psc_pkg.sv
`default_nettype none

package psc_pkg;

  localparam int unsigned AREA_BITS  = 50;
  localparam int unsigned CLASS_BITS = 3;

  typedef enum logic [CLASS_BITS-1:0] {
    POS_LEFT        = 3'd0,
    POS_RIGHT       = 3'd1,
    POS_BEHIND      = 3'd2,
    POS_BEYOND      = 3'd3,
    POS_ORIGIN      = 3'd4,
    POS_DESTINATION = 3'd5,
    POS_BETWEEN     = 3'd6
  } pos_class_e;

  // exact point matches found at the input stage
  typedef struct packed {
    logic origin;
    logic dest;
  } point_eq_t;

  // collinear tie-break flags carried down the pipe
  typedef struct packed {
    logic behind;
    logic origin;
    logic dest;
  } coll_flags_t;

endpackage

`default_nettype wire

### sv/psc_diff.sv
`default_nettype none

module psc_diff #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic signed [COORD_BITS-1:0] p1_x_i,
  input  wire logic signed [COORD_BITS-1:0] p1_y_i,
  input  wire logic signed [COORD_BITS-1:0] p2_x_i,
  input  wire logic signed [COORD_BITS-1:0] p2_y_i,
  input  wire logic signed [COORD_BITS-1:0] p3_x_i,
  input  wire logic signed [COORD_BITS-1:0] p3_y_i,
  output logic                              valid_o,
  output logic signed [COORD_BITS:0]        ax_o,
  output logic signed [COORD_BITS:0]        ay_o,
  output logic signed [COORD_BITS:0]        bx_o,
  output logic signed [COORD_BITS:0]        by_o,
  output psc_pkg::point_eq_t                eq_o
);

  logic                       valid_q;
  logic signed [COORD_BITS:0] ax_d, ay_d, bx_d, by_d;
  logic signed [COORD_BITS:0] ax_q, ay_q, bx_q, by_q;
  psc_pkg::point_eq_t         eq_d, eq_q;

  always_comb begin
    ax_d = {p2_x_i[COORD_BITS-1], p2_x_i} - {p1_x_i[COORD_BITS-1], p1_x_i};
    ay_d = {p2_y_i[COORD_BITS-1], p2_y_i} - {p1_y_i[COORD_BITS-1], p1_y_i};
    bx_d = {p3_x_i[COORD_BITS-1], p3_x_i} - {p1_x_i[COORD_BITS-1], p1_x_i};
    by_d = {p3_y_i[COORD_BITS-1], p3_y_i} - {p1_y_i[COORD_BITS-1], p1_y_i};
    eq_d.origin = (p3_x_i == p1_x_i) && (p3_y_i == p1_y_i);
    eq_d.dest   = (p3_x_i == p2_x_i) && (p3_y_i == p2_y_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= ax_d;
    ay_q <= ay_d;
    bx_q <= bx_d;
    by_q <= by_d;
    eq_q <= eq_d;
  end

  assign valid_o = valid_q;
  assign ax_o    = ax_q;
  assign ay_o    = ay_q;
  assign bx_o    = bx_q;
  assign by_o    = by_q;
  assign eq_o    = eq_q;

endmodule

`default_nettype wire

### sv/psc_prod.sv
`default_nettype none

module psc_prod #(
  parameter int unsigned COORD_BITS = 24,
  localparam int unsigned PROD_W    = 2 * COORD_BITS + 2
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire logic signed [COORD_BITS:0] ax_i,
  input  wire logic signed [COORD_BITS:0] ay_i,
  input  wire logic signed [COORD_BITS:0] bx_i,
  input  wire logic signed [COORD_BITS:0] by_i,
  input  wire psc_pkg::point_eq_t         eq_i,
  output logic                            valid_o,
  output logic signed [PROD_W-1:0]        axby_o,
  output logic signed [PROD_W-1:0]        aybx_o,
  output logic signed [PROD_W-1:0]        axax_o,
  output logic signed [PROD_W-1:0]        ayay_o,
  output logic signed [PROD_W-1:0]        bxbx_o,
  output logic signed [PROD_W-1:0]        byby_o,
  output psc_pkg::coll_flags_t            flags_o
);

  logic                     valid_q;
  logic signed [PROD_W-1:0] axby_d, aybx_d, axax_d, ayay_d, bxbx_d, byby_d;
  logic signed [PROD_W-1:0] axby_q, aybx_q, axax_q, ayay_q, bxbx_q, byby_q;
  logic                     ax_neg, ax_pos, ay_neg, ay_pos;
  logic                     bx_neg, bx_pos, by_neg, by_pos;
  psc_pkg::coll_flags_t     flags_d, flags_q;

  always_comb begin
    axby_d = ax_i * by_i;
    aybx_d = ay_i * bx_i;
    axax_d = ax_i * ax_i;
    ayay_d = ay_i * ay_i;
    bxbx_d = bx_i * bx_i;
    byby_d = by_i * by_i;

    ax_neg = ax_i[COORD_BITS];
    ay_neg = ay_i[COORD_BITS];
    bx_neg = bx_i[COORD_BITS];
    by_neg = by_i[COORD_BITS];
    ax_pos = !ax_neg && (|ax_i);
    ay_pos = !ay_neg && (|ay_i);
    bx_pos = !bx_neg && (|bx_i);
    by_pos = !by_neg && (|by_i);

    // strictly opposite signs on either axis
    flags_d.behind = (ax_neg && bx_pos) || (ax_pos && bx_neg) ||
                     (ay_neg && by_pos) || (ay_pos && by_neg);
    flags_d.origin = eq_i.origin;
    flags_d.dest   = eq_i.dest;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    axby_q  <= axby_d;
    aybx_q  <= aybx_d;
    axax_q  <= axax_d;
    ayay_q  <= ayay_d;
    bxbx_q  <= bxbx_d;
    byby_q  <= byby_d;
    flags_q <= flags_d;
  end

  assign valid_o = valid_q;
  assign axby_o  = axby_q;
  assign aybx_o  = aybx_q;
  assign axax_o  = axax_q;
  assign ayay_o  = ayay_q;
  assign bxbx_o  = bxbx_q;
  assign byby_o  = byby_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

### sv/psc_resolve.sv
`default_nettype none

module psc_resolve #(
  parameter int unsigned COORD_BITS = 24,
  localparam int unsigned PROD_W    = 2 * COORD_BITS + 2,
  localparam int unsigned CMP_W     =
    ((PROD_W > psc_pkg::AREA_BITS) ? PROD_W : psc_pkg::AREA_BITS) + 1
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  input  wire logic signed [PROD_W-1:0]           axby_i,
  input  wire logic signed [PROD_W-1:0]           aybx_i,
  input  wire logic signed [PROD_W-1:0]           axax_i,
  input  wire logic signed [PROD_W-1:0]           ayay_i,
  input  wire logic signed [PROD_W-1:0]           bxbx_i,
  input  wire logic signed [PROD_W-1:0]           byby_i,
  input  wire psc_pkg::coll_flags_t               flags_i,
  input  wire logic [psc_pkg::AREA_BITS-1:0]      tol_i,
  input  wire logic signed [CMP_W-1:0]            neg_tol_i,
  output logic                                    valid_o,
  output psc_pkg::pos_class_e                     class_o,
  output logic signed [psc_pkg::AREA_BITS-1:0]    area_o
);

  // sum stage
  logic                     sum_valid_q;
  logic signed [PROD_W-1:0] cross_d, cross_q;
  logic signed [PROD_W-1:0] la_d, la_q, lb_d, lb_q;
  psc_pkg::coll_flags_t     sum_flags_q;

  // classify stage
  logic signed [CMP_W-1:0]              cross_ext;
  logic signed [CMP_W-1:0]              tol_ext;
  logic                                 collinear;
  psc_pkg::pos_class_e                  class_d, class_q;
  logic                                 out_valid_q;
  logic signed [psc_pkg::AREA_BITS-1:0] area_q;

  always_comb begin
    cross_d = axby_i - aybx_i;
    la_d    = axax_i + ayay_i;
    lb_d    = bxbx_i + byby_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_valid_q <= valid_i;
      out_valid_q <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cross_q     <= cross_d;
    la_q        <= la_d;
    lb_q        <= lb_d;
    sum_flags_q <= flags_i;
  end

  always_comb begin
    cross_ext = {{(CMP_W - PROD_W){cross_q[PROD_W-1]}}, cross_q};
    tol_ext   = {{(CMP_W - psc_pkg::AREA_BITS){1'b0}}, tol_i};
    // cross is zero or |cross| < tol, strict on both sides
    collinear = (cross_q == '0) || ((cross_ext < tol_ext) && (cross_ext > neg_tol_i));
    if (collinear) begin
      if (sum_flags_q.behind) begin
        class_d = psc_pkg::POS_BEHIND;
      end else if (la_q < lb_q) begin
        class_d = psc_pkg::POS_BEYOND;
      end else if (sum_flags_q.origin) begin
        class_d = psc_pkg::POS_ORIGIN;
      end else if (sum_flags_q.dest) begin
        class_d = psc_pkg::POS_DESTINATION;
      end else begin
        class_d = psc_pkg::POS_BETWEEN;
      end
    end else if (cross_q[PROD_W-1]) begin
      class_d = psc_pkg::POS_RIGHT;
    end else begin
      class_d = psc_pkg::POS_LEFT;
    end
  end

  always_ff @(posedge clk_i) begin
    class_q <= class_d;
    area_q  <= cross_ext[psc_pkg::AREA_BITS-1:0];
  end

  assign valid_o = out_valid_q;
  assign class_o = class_q;
  assign area_o  = area_q;

endmodule

`default_nettype wire

### sv/point_segment_classifier_top.sv
`default_nettype none

// Classifies point p3 against the directed segment p1->p2 as left, right,
// behind, beyond, origin, destination or between, and reports the raw doubled
// signed area. Fully pipelined: one request is taken every clock cycle (busy
// stays low). Each result is strobed on done_o after the last stage, in
// request order. The four stages are the coordinate differences, the six
// products (one multiplier deep), the cross and squared-length sums, and the
// tolerance compare with class select. The receiver cannot stall, so results
// must be captured in their single strobe cycle. The collinear tolerance may
// be written at any time the pipe is empty; cfg_ready_o is always high.
module point_segment_classifier_top #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [COORD_BITS-1:0]        p1_x_i,
  input  wire logic signed [COORD_BITS-1:0]        p1_y_i,
  input  wire logic signed [COORD_BITS-1:0]        p2_x_i,
  input  wire logic signed [COORD_BITS-1:0]        p2_y_i,
  input  wire logic signed [COORD_BITS-1:0]        p3_x_i,
  input  wire logic signed [COORD_BITS-1:0]        p3_y_i,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [psc_pkg::AREA_BITS-1:0]       cfg_data_i,
  output logic                                     done_o,
  output logic [psc_pkg::CLASS_BITS-1:0]           position_class_o,
  output logic signed [psc_pkg::AREA_BITS-1:0]     doubled_area_o
);

  localparam int unsigned PROD_W = 2 * COORD_BITS + 2;
  localparam int unsigned CMP_W  =
    ((PROD_W > psc_pkg::AREA_BITS) ? PROD_W : psc_pkg::AREA_BITS) + 1;

  logic [psc_pkg::AREA_BITS-1:0] tol_q;
  logic signed [CMP_W-1:0]       neg_tol_q;

  logic                       d_valid;
  logic signed [COORD_BITS:0] ax, ay, bx, by;
  psc_pkg::point_eq_t         eq;

  logic                     p_valid;
  logic signed [PROD_W-1:0] axby, aybx, axax, ayay, bxbx, byby;
  psc_pkg::coll_flags_t     flags;

  psc_pkg::pos_class_e res_class;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q     <= '0;
      neg_tol_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q     <= cfg_data_i;
      neg_tol_q <= -$signed({{(CMP_W - psc_pkg::AREA_BITS){1'b0}}, cfg_data_i});
    end
  end

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  psc_diff #(
    .COORD_BITS(COORD_BITS)
  ) u_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .p1_x_i  (p1_x_i),
    .p1_y_i  (p1_y_i),
    .p2_x_i  (p2_x_i),
    .p2_y_i  (p2_y_i),
    .p3_x_i  (p3_x_i),
    .p3_y_i  (p3_y_i),
    .valid_o (d_valid),
    .ax_o    (ax),
    .ay_o    (ay),
    .bx_o    (bx),
    .by_o    (by),
    .eq_o    (eq)
  );

  psc_prod #(
    .COORD_BITS(COORD_BITS)
  ) u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .ax_i    (ax),
    .ay_i    (ay),
    .bx_i    (bx),
    .by_i    (by),
    .eq_i    (eq),
    .valid_o (p_valid),
    .axby_o  (axby),
    .aybx_o  (aybx),
    .axax_o  (axax),
    .ayay_o  (ayay),
    .bxbx_o  (bxbx),
    .byby_o  (byby),
    .flags_o (flags)
  );

  psc_resolve #(
    .COORD_BITS(COORD_BITS)
  ) u_resolve (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (p_valid),
    .axby_i    (axby),
    .aybx_i    (aybx),
    .axax_i    (axax),
    .ayay_i    (ayay),
    .bxbx_i    (bxbx),
    .byby_i    (byby),
    .flags_i   (flags),
    .tol_i     (tol_q),
    .neg_tol_i (neg_tol_q),
    .valid_o   (done_o),
    .class_o   (res_class),
    .area_o    (doubled_area_o)
  );

  assign position_class_o = res_class;

endmodule

`default_nettype wire

### sv/psc_checker.sv
`default_nettype none

module psc_checker #(
  parameter int unsigned COORD_BITS = 24
) (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic                                done_o,
  input wire logic [psc_pkg::CLASS_BITS-1:0]      position_class_o,
  input wire logic signed [psc_pkg::AREA_BITS-1:0] doubled_area_o
);

  localparam bit AREA_EXACT = (COORD_BITS <= 24);

  // every request yields its result on done_o
  a_request_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 done_o)
    else $error("request did not produce a result after four cycles");

  // no result without a matching earlier request
  a_done_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 4))
    else $error("result strobe without a matching request");

  a_left_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (AREA_EXACT && done_o && position_class_o == psc_pkg::POS_LEFT) |->
      (!doubled_area_o[psc_pkg::AREA_BITS-1] && doubled_area_o != '0))
    else $error("left class with non-positive area");

  a_right_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (AREA_EXACT && done_o && position_class_o == psc_pkg::POS_RIGHT) |->
      doubled_area_o[psc_pkg::AREA_BITS-1])
    else $error("right class with non-negative area");

endmodule

bind point_segment_classifier_top psc_checker #(
  .COORD_BITS(COORD_BITS)
) u_psc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .position_class_o (position_class_o),
  .doubled_area_o   (doubled_area_o)
);

`default_nettype wire
